FILE: src/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed: next-cycle implication");

`endif

FILE: src/pts_pkg.sv
// Package for the process table scheduler: operation, state and policy codes,
// the result word type, the controller state type and default parameters.
`default_nettype none

package pts_pkg;

    localparam int NUM_SLOTS_DEF  = 64;
    localparam int COUNT_BITS_DEF = 32;

    localparam logic [2:0] FN_TICK     = 3'd0;
    localparam logic [2:0] FN_PICK     = 3'd1;
    localparam logic [2:0] FN_SET_ST   = 3'd2;
    localparam logic [2:0] FN_SET_PRIO = 3'd3;
    localparam logic [2:0] FN_ALLOC    = 3'd4;
    localparam logic [2:0] FN_READ     = 3'd5;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_EMBRYO   = 3'd1;
    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_RUNNABLE = 3'd3;
    localparam logic [2:0] ST_RUNNING  = 3'd4;
    localparam logic [2:0] ST_ZOMBIE   = 3'd5;

    localparam logic [1:0] POL_RR     = 2'd0;
    localparam logic [1:0] POL_CREATE = 2'd1;
    localparam logic [1:0] POL_PRIO   = 2'd2;

    localparam logic [6:0] PRIO_MAX     = 7'd100;
    localparam logic [6:0] PRIO_DEFAULT = 7'd60;
    localparam logic [6:0] PRIO_FIRST   = 7'd1;

    typedef struct packed {
        logic        ok;
        logic [5:0]  result_slot;
        logic [15:0] result_pid;
        logic [6:0]  prev_prio;
        logic [31:0] run_ticks;
        logic [31:0] wait_ticks;
        logic [31:0] sleep_ticks;
        logic [31:0] times_chosen;
    } pts_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_FETCH   = 5'b00100,
        S_APPLY   = 5'b01000,
        S_DELIVER = 5'b10000
    } pts_fsm_t;

endpackage

`default_nettype wire

FILE: src/pts_req_if.sv
// Request channel of the scheduler: one operation word per handshake.
// Stands alone; fixed field widths.
`default_nettype none

interface pts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [5:0]  slot;
    logic [15:0] target_pid;
    logic [2:0]  new_state;
    logic [6:0]  req_prio;

    modport source (output valid, func, slot, target_pid, new_state, req_prio,
                    input ready);
    modport sink   (input valid, func, slot, target_pid, new_state, req_prio,
                    output ready);
endinterface

`default_nettype wire

FILE: src/pts_rsp_if.sv
// Result channel of the scheduler: one result word per handshake.
// Stands alone; fixed field widths.
`default_nettype none

interface pts_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [5:0]  result_slot;
    logic [15:0] result_pid;
    logic [6:0]  prev_prio;
    logic [31:0] run_ticks;
    logic [31:0] wait_ticks;
    logic [31:0] sleep_ticks;
    logic [31:0] times_chosen;

    modport source (output valid, ok, result_slot, result_pid, prev_prio, run_ticks,
                    wait_ticks, sleep_ticks, times_chosen, input ready);
    modport sink   (input valid, ok, result_slot, result_pid, prev_prio, run_ticks,
                    wait_ticks, sleep_ticks, times_chosen, output ready);
endinterface

`default_nettype wire

FILE: src/pts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

FILE: src/process_table_scheduler_top.sv
// Top level of the process table scheduler: controller, slot table RAM, result register.
// Depends on pts_pkg, pts_req_if, pts_rsp_if, pts_ram and assert_macros.svh.
//
//  Channel | Direction | Handshake       | Carries
//  req     | in        | valid / ready   | func, slot, target_pid, new_state, req_prio
//  rsp     | out       | valid / ready   | ok, slot, pid, priority, four counters
//  cfg     | in        | cfg_we          | policy_mode in cfg_wdata
//
// Tick, pick, set priority and allocate walk the whole table through the RAM's single
// read port, one slot per cycle. A walk that finds a slot then fetches and updates it;
// a tick or a failed search goes straight to the result, as do invalid words. Set state
// and read stats fetch the addressed slot directly; set state also updates it.
// Reset is asynchronous and marks every slot unused; no clearing pass is needed.
// Ready returns as the result loads, so the next word is taken even while the result waits
// on rsp; a finished result waits in the controller until the output register frees up.
`default_nettype none

`include "assert_macros.svh"

module process_table_scheduler_top #(
    parameter int NUM_SLOTS  = pts_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_BITS = pts_pkg::COUNT_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    pts_req_if.sink         req,
    pts_rsp_if.source       rsp,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata
);
    import pts_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    // Layout of one table word.
    localparam int PR_LSB  = 3;
    localparam int PID_LSB = 10;
    localparam int CR_LSB  = 26;
    localparam int RUN_LSB = 58;
    localparam int WT_LSB  = RUN_LSB + COUNT_BITS;
    localparam int SL_LSB  = RUN_LSB + 2 * COUNT_BITS;
    localparam int CH_LSB  = RUN_LSB + 3 * COUNT_BITS;
    localparam int EW      = RUN_LSB + 4 * COUNT_BITS;

    pts_fsm_t state_reg, state_next;

    logic [2:0]           op_reg, op_next;
    logic [SW-1:0]        hit_reg, hit_next;
    logic [15:0]          tpid_reg, tpid_next;
    logic [2:0]           nstate_reg, nstate_next;
    logic [6:0]           nprio_reg, nprio_next;
    logic [1:0]           policy_reg;
    logic [31:0]          tick_reg, tick_next;
    logic [15:0]          next_pid_reg, next_pid_next;
    logic [SW-1:0]        rr_reg, rr_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [SW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 found_reg, found_next;
    logic [31:0]          key_reg, key_next;
    pts_rsp_t             res_reg, res_next;
    pts_rsp_t             out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic          ram_we;
    logic [SW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [SW-1:0] ram_raddr;
    logic [EW-1:0] rd_data;

    // Decoded fields of the word returned by the RAM.
    logic [2:0]            rd_st;
    logic [6:0]            rd_prio;
    logic [15:0]           rd_pid;
    logic [31:0]           rd_create;
    logic [COUNT_BITS-1:0] rd_run, rd_wait, rd_sleep, rd_chosen;

    logic [SW:0]   rr_sum;
    logic [SW-1:0] scan_addr;
    logic          rr_mode;
    logic          take;
    logic          accept;
    logic          load_out;

    pts_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // A slot never written since reset reads as unused; its other fields are don't-care.
    always_comb
    begin
        rd_st     = valid_reg[rd_idx_reg] ? rd_data[2:0] : ST_UNUSED;
        rd_prio   = rd_data[PR_LSB +: 7];
        rd_pid    = rd_data[PID_LSB +: 16];
        rd_create = rd_data[CR_LSB +: 32];
        rd_run    = rd_data[RUN_LSB +: COUNT_BITS];
        rd_wait   = rd_data[WT_LSB +: COUNT_BITS];
        rd_sleep  = rd_data[SL_LSB +: COUNT_BITS];
        rd_chosen = rd_data[CH_LSB +: COUNT_BITS];
    end

    // Round robin picks start at the pointer and wrap; all other walks start at slot zero.
    assign rr_mode   = (policy_reg != POL_CREATE) && (policy_reg != POL_PRIO);
    assign rr_sum    = {1'b0, rr_reg} + {1'b0, cnt_reg[SW-1:0]};
    assign scan_addr = ((op_reg == FN_PICK) && rr_mode)
                     ? ((rr_sum >= (SW+1)'(NUM_SLOTS)) ? SW'(rr_sum - (SW+1)'(NUM_SLOTS))
                                                         : SW'(rr_sum))
                     : SW'(cnt_reg);
    assign ram_raddr = (state_reg == S_FETCH) ? hit_reg : scan_addr;

    assign accept   = req.valid && req.ready;
    assign load_out = (state_reg == S_DELIVER) && (!out_valid_reg || rsp.ready);

    // Does the slot under the read pointer win the running search?
    always_comb
    begin
        take = 1'b0;
        case (op_reg)
            FN_PICK:
            begin
                if (rd_st == ST_RUNNABLE)
                begin
                    if (!found_reg)
                        take = 1'b1;
                    else if (policy_reg == POL_CREATE)
                        take = rd_create < key_reg;
                    else if (policy_reg == POL_PRIO)
                        take = rd_prio < key_reg[6:0];
                end
            end
            FN_SET_PRIO: take = !found_reg && (rd_st != ST_UNUSED) && (rd_pid == tpid_reg);
            FN_ALLOC:    take = !found_reg && (rd_st == ST_UNUSED);
            default:     take = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        hit_next       = hit_reg;
        tpid_next      = tpid_reg;
        nstate_next    = nstate_reg;
        nprio_next     = nprio_reg;
        tick_next      = tick_reg;
        next_pid_next  = next_pid_reg;
        rr_next        = rr_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        found_next     = found_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = rd_idx_reg;
        ram_wdata      = rd_data;

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.func;
                    hit_next    = SW'(req.slot);
                    tpid_next   = req.target_pid;
                    nstate_next = req.new_state;
                    nprio_next  = req.req_prio;
                    cnt_next    = '0;
                    found_next  = 1'b0;
                    res_next    = '0;
                    state_next  = S_DELIVER;
                    case (req.func)
                        FN_TICK, FN_PICK, FN_ALLOC:
                            state_next = S_SCAN;
                        FN_SET_PRIO:
                            if (req.req_prio <= PRIO_MAX)
                                state_next = S_SCAN;
                        FN_SET_ST:
                            if ((int'(req.slot) < NUM_SLOTS) && (req.new_state <= ST_ZOMBIE))
                                state_next = S_FETCH;
                        FN_READ:
                            if (int'(req.slot) < NUM_SLOTS)
                                state_next = S_FETCH;
                        default:
                            state_next = S_DELIVER;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (cnt_reg < CW'(NUM_SLOTS))
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = scan_addr;
                    cnt_next    = cnt_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    if (op_reg == FN_TICK)
                    begin
                        // Read-modify-write of one counter; the next read is another slot.
                        case (rd_st)
                            ST_RUNNING:
                            begin
                                ram_we = 1'b1;
                                ram_wdata[RUN_LSB +: COUNT_BITS] = rd_run + COUNT_BITS'(1);
                            end
                            ST_RUNNABLE:
                            begin
                                ram_we = 1'b1;
                                ram_wdata[WT_LSB +: COUNT_BITS] = rd_wait + COUNT_BITS'(1);
                            end
                            ST_SLEEPING:
                            begin
                                ram_we = 1'b1;
                                ram_wdata[SL_LSB +: COUNT_BITS] = rd_sleep + COUNT_BITS'(1);
                            end
                            default:
                                ram_we = 1'b0;
                        endcase
                    end
                    else if (take)
                    begin
                        found_next = 1'b1;
                        hit_next   = rd_idx_reg;
                        key_next   = (policy_reg == POL_CREATE) ? rd_create
                                                                : {25'd0, rd_prio};
                    end
                    if (cnt_reg == CW'(NUM_SLOTS))
                    begin
                        if (op_reg == FN_TICK)
                        begin
                            tick_next   = tick_reg + 32'd1;
                            res_next.ok = 1'b1;
                            state_next  = S_DELIVER;
                        end
                        else if (found_next)
                            state_next = S_FETCH;
                        else
                            state_next = S_DELIVER;
                    end
                end
            end

            S_FETCH:
            begin
                rd_vld_next = 1'b1;
                rd_idx_next = hit_reg;
                state_next  = S_APPLY;
            end

            S_APPLY:
            begin
                ram_waddr                = hit_reg;
                res_next.ok              = 1'b1;
                res_next.result_slot     = 6'(hit_reg);
                res_next.result_pid      = rd_pid;
                res_next.prev_prio       = rd_prio;
                state_next               = S_DELIVER;
                case (op_reg)
                    FN_PICK:
                    begin
                        ram_we = 1'b1;
                        ram_wdata[2:0] = ST_RUNNING;
                        ram_wdata[CH_LSB +: COUNT_BITS] = rd_chosen + COUNT_BITS'(1);
                        rr_next = (hit_reg == SW'(NUM_SLOTS - 1)) ? '0 : hit_reg + SW'(1);
                        res_next.run_ticks    = 32'(rd_run);
                        res_next.wait_ticks   = 32'(rd_wait);
                        res_next.sleep_ticks  = 32'(rd_sleep);
                        res_next.times_chosen = 32'(rd_chosen + COUNT_BITS'(1));
                    end
                    FN_SET_ST:
                    begin
                        ram_we = 1'b1;
                        ram_wdata[2:0] = nstate_reg;
                        valid_next[hit_reg] = 1'b1;
                    end
                    FN_SET_PRIO:
                    begin
                        ram_we = 1'b1;
                        ram_wdata[PR_LSB +: 7] = nprio_reg;
                    end
                    FN_ALLOC:
                    begin
                        ram_we = 1'b1;
                        ram_wdata = '0;
                        ram_wdata[2:0] = ST_EMBRYO;
                        ram_wdata[PID_LSB +: 16] = next_pid_reg;
                        ram_wdata[CR_LSB +: 32] = tick_reg;
                        ram_wdata[PR_LSB +: 7] =
                            ((next_pid_reg == 16'd1) || (next_pid_reg == 16'd2))
                            ? PRIO_FIRST : PRIO_DEFAULT;
                        valid_next[hit_reg] = 1'b1;
                        next_pid_next = next_pid_reg + 16'd1;
                        res_next.result_pid = next_pid_reg;
                        res_next.prev_prio  = ram_wdata[PR_LSB +: 7];
                    end
                    FN_READ:
                    begin
                        res_next.run_ticks    = 32'(rd_run);
                        res_next.wait_ticks   = 32'(rd_wait);
                        res_next.sleep_ticks  = 32'(rd_sleep);
                        res_next.times_chosen = 32'(rd_chosen);
                    end
                    default:
                        ram_we = 1'b0;
                endcase
            end

            S_DELIVER:
            begin
                if (load_out)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= POL_RR;
            tick_reg      <= '0;
            next_pid_reg  <= 16'd1;
            rr_reg        <= '0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
                policy_reg <= cfg_wdata;
            tick_reg      <= tick_next;
            next_pid_reg  <= next_pid_next;
            rr_reg        <= rr_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        hit_reg    <= hit_next;
        tpid_reg   <= tpid_next;
        nstate_reg <= nstate_next;
        nprio_reg  <= nprio_next;
        rd_idx_reg <= rd_idx_next;
        key_reg    <= key_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.ok           = out_reg.ok;
    assign rsp.result_slot  = out_reg.result_slot;
    assign rsp.result_pid   = out_reg.result_pid;
    assign rsp.prev_prio    = out_reg.prev_prio;
    assign rsp.run_ticks    = out_reg.run_ticks;
    assign rsp.wait_ticks   = out_reg.wait_ticks;
    assign rsp.sleep_ticks  = out_reg.sleep_ticks;
    assign rsp.times_chosen = out_reg.times_chosen;

    // The table is only written by the tick walk or by the single-slot update.
    `PTS_ASSERT_IMPLY(a_write_phase, clk, rst_n, ram_we, (state_reg == S_SCAN) || (state_reg == S_APPLY))
    // The walk counter never runs past the table.
    `PTS_ASSERT_IMPLY(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CW'(NUM_SLOTS))
    // A fetch is always followed by its update step.
    `PTS_ASSERT_NEXT(a_fetch_apply, clk, rst_n, state_reg == S_FETCH, state_reg == S_APPLY)
    // A finished result reaches the output register once it is free.
    `PTS_ASSERT_NEXT(a_deliver, clk, rst_n, (state_reg == S_DELIVER) && (!rsp.valid || rsp.ready), rsp.valid && (state_reg == S_IDLE))

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the process table scheduler.
// Depends on pts_pkg, pts_req_if, pts_rsp_if and process_table_scheduler_top.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int SLOTS      = 64;
    localparam int STALL_MAX  = 6;
    // The slowest word walks the whole table, then fetches and updates a slot; add both sides' stalls.
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 80;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    pts_req_if req ();
    pts_rsp_if rsp ();

    process_table_scheduler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // One operation word as the sender puts it on the request channel.
    typedef struct {
        logic [2:0]  func;
        logic [5:0]  slot;
        logic [15:0] target_pid;
        logic [2:0]  new_state;
        logic [6:0]  req_prio;
    } op_word_t;

    // A row of the directed table. When has_fixed is set, fixed holds the result
    // that can be read off directly, and the predictor's answer is checked against it.
    typedef struct {
        op_word_t op;
        bit       has_fixed;
        pts_rsp_t fixed;
    } dir_row_t;

    // Local copy of the slot table, used to predict every result.
    logic [2:0]  tbl_state    [SLOTS];
    logic [6:0]  tbl_prio     [SLOTS];
    logic [15:0] tbl_pid      [SLOTS];
    logic [31:0] tbl_created  [SLOTS];
    logic [31:0] tbl_run      [SLOTS];
    logic [31:0] tbl_wait     [SLOTS];
    logic [31:0] tbl_sleep    [SLOTS];
    logic [31:0] tbl_chosen   [SLOTS];
    logic [31:0] now_tick;
    logic [15:0] pid_next;
    logic [5:0]  rr_next;
    logic [1:0]  policy;

    pts_rsp_t    pending_results[$];
    int          mismatches;
    int          words_sent;
    int          results_seen;
    int          idle_cycles;
    int          picks_ok;
    int          picks_empty;
    bit          rsp_ready_gate;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic pts_rsp_t slot_result(input int s, input bit with_counts);
        pts_rsp_t r;
        r = '0;
        r.ok           = 1'b1;
        r.result_slot  = s[5:0];
        r.result_pid   = tbl_pid[s];
        r.prev_prio    = tbl_prio[s];
        if (with_counts)
        begin
            r.run_ticks    = tbl_run[s];
            r.wait_ticks   = tbl_wait[s];
            r.sleep_ticks  = tbl_sleep[s];
            r.times_chosen = tbl_chosen[s];
        end
        return r;
    endfunction

    function automatic int choose_runnable();
        int best;
        int s;
        best = -1;
        if (policy == POL_CREATE || policy == POL_PRIO)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tbl_state[i] != ST_RUNNABLE)
                    continue;
                if (best < 0)
                    best = i;
                else if (policy == POL_CREATE && tbl_created[i] < tbl_created[best])
                    best = i;
                else if (policy == POL_PRIO && tbl_prio[i] < tbl_prio[best])
                    best = i;
            end
            return best;
        end
        // Round robin, which also covers the unused policy code three.
        for (int i = 0; i < SLOTS; i++)
        begin
            s = (int'(rr_next) + i) % SLOTS;
            if (tbl_state[s] == ST_RUNNABLE)
                return s;
        end
        return -1;
    endfunction

    // Applies one accepted word to the local table and returns the expected result.
    function automatic pts_rsp_t schedule_step(input op_word_t w);
        pts_rsp_t r;
        int       s;
        r = '0;
        case (w.func)
            FN_TICK:
            begin
                now_tick++;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_state[i] == ST_RUNNING)
                        tbl_run[i]++;
                    else if (tbl_state[i] == ST_RUNNABLE)
                        tbl_wait[i]++;
                    else if (tbl_state[i] == ST_SLEEPING)
                        tbl_sleep[i]++;
                end
                r.ok = 1'b1;
            end
            FN_PICK:
            begin
                s = choose_runnable();
                if (s >= 0)
                begin
                    tbl_state[s] = ST_RUNNING;
                    tbl_chosen[s]++;
                    rr_next = 6'((s + 1) % SLOTS);
                    r = slot_result(s, 1'b1);
                    picks_ok++;
                end
                else
                    picks_empty++;
            end
            FN_SET_ST:
            begin
                if (w.new_state <= ST_ZOMBIE)
                begin
                    tbl_state[w.slot] = w.new_state;
                    r = slot_result(int'(w.slot), 1'b0);
                end
            end
            FN_SET_PRIO:
            begin
                if (w.req_prio <= PRIO_MAX)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (tbl_state[i] != ST_UNUSED && tbl_pid[i] == w.target_pid)
                        begin
                            r = slot_result(i, 1'b0);
                            tbl_prio[i] = w.req_prio;
                            break;
                        end
                    end
                end
            end
            FN_ALLOC:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_state[i] == ST_UNUSED)
                    begin
                        tbl_state[i]   = ST_EMBRYO;
                        tbl_pid[i]     = pid_next;
                        tbl_created[i] = now_tick;
                        tbl_run[i]     = '0;
                        tbl_wait[i]    = '0;
                        tbl_sleep[i]   = '0;
                        tbl_chosen[i]  = '0;
                        tbl_prio[i]    = (pid_next == 16'd1 || pid_next == 16'd2) ?
                                         PRIO_FIRST : PRIO_DEFAULT;
                        pid_next++;
                        r = slot_result(i, 1'b1);
                        break;
                    end
                end
            end
            FN_READ:
                r = slot_result(int'(w.slot), 1'b1);
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // Every slot ever read must have been allocated first; the slot table starts
    // undefined apart from its state, so this tracks which entries hold data.
    bit written[SLOTS];

    function automatic bit slot_has_data(input logic [5:0] s);
        return written[s];
    endfunction

    // Waits for acceptance of one word, then records its expected result.
    task automatic send_word(input op_word_t w, input bit has_fixed, input pts_rsp_t fixed);
        pts_rsp_t predicted;
        int       gap;
        gap = $urandom_range(0, STALL_MAX);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        // The first edge lets valid of the previous word drop before the next one rises.
        repeat (gap + 1) @(posedge clk);
        req.valid        <= 1'b1;
        req.func         <= w.func;
        req.slot         <= w.slot;
        req.target_pid   <= w.target_pid;
        req.new_state    <= w.new_state;
        req.req_prio     <= w.req_prio;
        do
            @(posedge clk);
        while (!req.ready);
        req.valid <= 1'b0;
        predicted = schedule_step(w);
        if (w.func == FN_ALLOC && predicted.ok)
            written[predicted.result_slot] = 1'b1;
        if (has_fixed && predicted !== fixed)
            report_mismatch("directed row table entry vs predictor", 32'(words_sent), 32'd0);
        pending_results.push_back(predicted);
        words_sent++;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_policy(input logic [1:0] mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        policy = mode;
    endtask

    function automatic op_word_t make_op(input logic [2:0] f, input logic [5:0] s,
                                         input logic [15:0] p, input logic [2:0] st,
                                         input logic [6:0] pr);
        op_word_t w;
        w.func = f;
        w.slot = s;
        w.target_pid = p;
        w.new_state = st;
        w.req_prio = pr;
        return w;
    endfunction

    // Random word. Reads and state writes only address slots that already
    // hold data, so no never-written entry is ever read back.
    function automatic op_word_t random_op();
        op_word_t w;
        int       pick;
        logic [5:0] s;
        w = make_op(3'($urandom_range(0, 7)), 6'($urandom), 16'($urandom),
                    3'($urandom), 7'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 18)       w.func = FN_TICK;
        else if (pick < 36)  w.func = FN_PICK;
        else if (pick < 62)  w.func = FN_SET_ST;
        else if (pick < 74)  w.func = FN_SET_PRIO;
        else if (pick < 84)  w.func = FN_ALLOC;
        else if (pick < 96)  w.func = FN_READ;
        if (w.func == FN_SET_ST && $urandom_range(0, 9) != 0)
            w.new_state = ($urandom_range(0, 9) < 5) ? ST_RUNNABLE :
                          3'($urandom_range(0, 5));
        if (w.func == FN_SET_PRIO && $urandom_range(0, 5) != 0)
        begin
            w.req_prio   = 7'($urandom_range(0, 100));
            w.target_pid = (pid_next > 1 && $urandom_range(0, 4) != 0) ?
                           16'($urandom_range(1, int'(pid_next) - 1)) : w.target_pid;
        end
        if (w.func == FN_SET_ST || w.func == FN_READ)
        begin
            s = w.slot;
            if (!slot_has_data(s))
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (written[(int'(s) + i) % SLOTS])
                    begin
                        s = 6'((int'(s) + i) % SLOTS);
                        break;
                    end
            end
            w.slot = s;
            if (!slot_has_data(s))
                w.func = FN_ALLOC;
        end
        return w;
    endfunction

    // Result side: random stalls, then compare with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= rsp_ready_gate;
    end

    initial
    begin
        rsp_ready_gate = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 2) == 0)
                rsp_ready_gate = 1'b1;
            else
                rsp_ready_gate = ($urandom_range(0, STALL_MAX) == 0);
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        pts_rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected", 32'(results_seen), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp.ok !== want.ok)
                    report_mismatch("ok", 32'(rsp.ok), 32'(want.ok));
                if (rsp.result_slot !== want.result_slot)
                    report_mismatch("result_slot", 32'(rsp.result_slot), 32'(want.result_slot));
                if (rsp.result_pid !== want.result_pid)
                    report_mismatch("result_pid", 32'(rsp.result_pid), 32'(want.result_pid));
                if (rsp.prev_prio !== want.prev_prio)
                    report_mismatch("prev_prio", 32'(rsp.prev_prio),
                                    32'(want.prev_prio));
                if (rsp.run_ticks !== want.run_ticks)
                    report_mismatch("run_ticks", rsp.run_ticks, want.run_ticks);
                if (rsp.wait_ticks !== want.wait_ticks)
                    report_mismatch("wait_ticks", rsp.wait_ticks, want.wait_ticks);
                if (rsp.sleep_ticks !== want.sleep_ticks)
                    report_mismatch("sleep_ticks", rsp.sleep_ticks, want.sleep_ticks);
                if (rsp.times_chosen !== want.times_chosen)
                    report_mismatch("times_chosen", rsp.times_chosen, want.times_chosen);
            end
        end
    end

    // Watchdog: any cycle without a handshake on either channel counts as idle.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("** process_table_scheduler_top: FAILED **");
            $finish;
        end
    end

    dir_row_t directed[$];

    task automatic add_row(input op_word_t w, input bit has_fixed, input pts_rsp_t fixed);
        dir_row_t row;
        row.op = w;
        row.has_fixed = has_fixed;
        row.fixed = fixed;
        directed.push_back(row);
    endtask

    function automatic pts_rsp_t fixed_fail();
        return '0;
    endfunction

    function automatic pts_rsp_t fixed_alloc(input logic [5:0] s, input logic [15:0] p,
                                             input logic [6:0] pr);
        pts_rsp_t r;
        r = '0;
        r.ok = 1'b1;
        r.result_slot = s;
        r.result_pid = p;
        r.prev_prio = pr;
        return r;
    endfunction

    initial
    begin
        pts_rsp_t tick_ok;
        op_word_t w;
        int       target_words;

        req.valid = 1'b0;
        req.func = FN_TICK;
        req.slot = '0;
        req.target_pid = '0;
        req.new_state = ST_UNUSED;
        req.req_prio = '0;
        cfg_we = 1'b0;
        cfg_wdata = POL_RR;
        mismatches = 0;
        words_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        picks_ok = 0;
        picks_empty = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_state[i] = ST_UNUSED;
            tbl_prio[i] = '0;
            tbl_pid[i] = '0;
            tbl_created[i] = '0;
            tbl_run[i] = '0;
            tbl_wait[i] = '0;
            tbl_sleep[i] = '0;
            tbl_chosen[i] = '0;
            written[i] = 1'b0;
        end
        now_tick = '0;
        pid_next = 16'd1;
        rr_next = '0;
        policy = POL_RR;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Right after reset the table is empty, so a pick and a
        // pid search both fail; the first two pids get the boosted priority.
        tick_ok = '0;
        tick_ok.ok = 1'b1;
        add_row(make_op(FN_PICK, 6'd0, 16'd0, ST_UNUSED, 7'd0), 1'b1, fixed_fail());
        add_row(make_op(FN_SET_PRIO, 6'd0, 16'd1, ST_UNUSED, 7'd5), 1'b1, fixed_fail());
        add_row(make_op(FN_TICK, 6'd63, 16'hFFFF, 3'd7, 7'd127), 1'b1, tick_ok);
        add_row(make_op(FN_ALLOC, 6'd0, 16'd0, ST_UNUSED, 7'd0), 1'b1,
                fixed_alloc(6'd0, 16'd1, PRIO_FIRST));
        add_row(make_op(FN_ALLOC, 6'd0, 16'd0, ST_UNUSED, 7'd0), 1'b1,
                fixed_alloc(6'd1, 16'd2, PRIO_FIRST));
        add_row(make_op(FN_ALLOC, 6'd0, 16'd0, ST_UNUSED, 7'd0), 1'b1,
                fixed_alloc(6'd2, 16'd3, PRIO_DEFAULT));
        // Unknown operation codes, an out-of-range state or priority, and an unknown pid fail.
        add_row(make_op(3'd6, 6'd1, 16'd1, ST_RUNNABLE, 7'd1), 1'b1, fixed_fail());
        add_row(make_op(3'd7, 6'd1, 16'd1, ST_RUNNABLE, 7'd1), 1'b1, fixed_fail());
        add_row(make_op(FN_SET_ST, 6'd1, 16'd0, 3'd6, 7'd0), 1'b1, fixed_fail());
        add_row(make_op(FN_SET_ST, 6'd2, 16'd0, 3'd7, 7'd0), 1'b1, fixed_fail());
        add_row(make_op(FN_SET_PRIO, 6'd0, 16'd3, ST_UNUSED, 7'd101), 1'b1, fixed_fail());
        add_row(make_op(FN_SET_PRIO, 6'd0, 16'd3, ST_UNUSED, 7'd127), 1'b1, fixed_fail());
        add_row(make_op(FN_SET_PRIO, 6'd0, 16'hFFFF, ST_UNUSED, 7'd0), 1'b1, fixed_fail());
        // Priority extremes, every state, and picks with state counters moving.
        add_row(make_op(FN_SET_PRIO, 6'd0, 16'd3, ST_UNUSED, 7'd100), 1'b0, '0);
        add_row(make_op(FN_SET_PRIO, 6'd0, 16'd2, ST_UNUSED, 7'd0), 1'b0, '0);
        add_row(make_op(FN_SET_ST, 6'd0, 16'd0, ST_RUNNABLE, 7'd0), 1'b0, '0);
        add_row(make_op(FN_SET_ST, 6'd1, 16'd0, ST_SLEEPING, 7'd0), 1'b0, '0);
        add_row(make_op(FN_SET_ST, 6'd2, 16'd0, ST_RUNNABLE, 7'd0), 1'b0, '0);
        add_row(make_op(FN_TICK, 6'd0, 16'd0, ST_UNUSED, 7'd0), 1'b0, '0);
        add_row(make_op(FN_PICK, 6'd0, 16'd0, ST_UNUSED, 7'd0), 1'b0, '0);
        add_row(make_op(FN_TICK, 6'd0, 16'd0, ST_UNUSED, 7'd0), 1'b0, '0);
        add_row(make_op(FN_SET_ST, 6'd2, 16'd0, ST_ZOMBIE, 7'd0), 1'b0, '0);
        add_row(make_op(FN_SET_ST, 6'd1, 16'd0, ST_EMBRYO, 7'd0), 1'b0, '0);
        add_row(make_op(FN_READ, 6'd0, 16'd0, ST_UNUSED, 7'd0), 1'b0, '0);
        add_row(make_op(FN_SET_ST, 6'd2, 16'd0, ST_UNUSED, 7'd0), 1'b0, '0);
        foreach (directed[i])
            send_word(directed[i].op, directed[i].has_fixed, directed[i].fixed);

        // Random phases, one per policy code including the spare code three,
        // ending back on round robin. The register is only written once drained.
        target_words = 600;
        for (int phase = 0; phase < 5; phase++)
        begin
            wait_drained();
            write_policy((phase == 4) ? POL_RR : 2'(phase));
            for (int n = 0; n < target_words / 5; n++)
            begin
                // Once per phase, hold the sender until every result is back.
                if (n == 40)
                    while (pending_results.size() != 0)
                        @(posedge clk);
                w = random_op();
                send_word(w, 1'b0, '0);
            end
        end

        wait_drained();
        $display("covered %0d words, %0d picks (%0d on an empty table), all four policy codes",
                 words_sent, picks_ok + picks_empty, picks_empty);
        $display("results checked: %0d, mismatches: %0d", results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** process_table_scheduler_top: PASSED **");
        else
            $display("** process_table_scheduler_top: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire
